// ===== src/lidar_front_obstacle_detector_macros.svh =====
// Assertion helpers for the checker file of the obstacle detector.
`ifndef LIDAR_FRONT_OBSTACLE_DETECTOR_MACROS_SVH
`define LIDAR_FRONT_OBSTACLE_DETECTOR_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define LFOD_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("lfod assertion failed");

// Next-cycle implication, disabled while reset is high.
`define LFOD_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("lfod assertion failed");

`endif

// ===== src/lfod_pkg.sv =====
package lfod_pkg;

   // Build-time defaults for the top-level parameters.
   localparam int HEADER_LEN_DEF  = 7;
   localparam int MEDIAN_TAPS_DEF = 5;

   // Scan sample framing is fixed by the sensor protocol.
   localparam int SAMPLE_LEN = 5;
   localparam int SC_W       = $clog2(SAMPLE_LEN);
   localparam int SB_W       = $clog2(SAMPLE_LEN - 1);

   localparam int QUEUE_DEPTH = 4;

   localparam logic [7:0]  LEAD_FIRST    = 8'hA5;
   localparam logic [7:0]  LEAD_SECOND   = 8'h5A;
   localparam logic [1:0]  LEAD_NONE     = 2'b00;
   localparam logic [1:0]  LEAD_FIRST_OK = 2'b01;
   localparam logic [1:0]  LEAD_SECOND_OK = 2'b10;
   localparam logic [1:0]  LEAD_BOTH     = 2'b11;
   localparam logic [7:0]  COUNT_MAX     = 8'hFF;
   localparam logic [15:0] RESET_DIST_Q2 = 16'd4000;

   localparam logic [15:0] NEAR_THRESHOLD_RST = 16'd1200;
   localparam logic [7:0]  CONFIRM_NEEDED_RST = 8'd5;
   localparam logic [7:0]  CLEAR_NEEDED_RST   = 8'd10;
   localparam logic [15:0] MIN_VALID_RST      = 16'd200;
   localparam logic [15:0] MAX_VALID_RST      = 16'd4000;
   localparam logic [14:0] SECTOR_START_RST   = 15'd22080;
   localparam logic [14:0] SECTOR_END_RST     = 15'd960;

   localparam logic OP_BYTE = 1'b0;
   localparam logic OP_TICK = 1'b1;

   typedef enum logic [2:0] {
      CSR_NEAR_THRESHOLD,
      CSR_CONFIRM_NEEDED,
      CSR_CLEAR_NEEDED,
      CSR_MIN_VALID,
      CSR_MAX_VALID,
      CSR_SECTOR_START,
      CSR_SECTOR_END
   } csr_index_type;

   // What the back end has to do with a queued request.
   typedef enum logic [1:0] {
      KIND_NONE,
      KIND_REPORT,
      KIND_INSERT,
      KIND_TICK
   } kind_type;

   typedef struct packed {
      logic       opcode;
      logic [7:0] rx_byte;
   } req_type;

   typedef struct packed {
      logic        scan_active;
      logic        sample_done;
      logic [14:0] bearing_q6;
      logic [15:0] range_q2;
      logic [15:0] median_q2;
      logic [15:0] front_range_q2;
      logic        obstacle;
   } rsp_type;

   typedef struct packed {
      logic [15:0] near_threshold_q2;
      logic [7:0]  confirm_needed;
      logic [7:0]  clear_needed;
      logic [15:0] min_valid_q2;
      logic [15:0] max_valid_q2;
      logic [14:0] sector_start_q6;
      logic [14:0] sector_end_q6;
   } cfg_type;

   typedef struct packed {
      kind_type    kind;
      logic        scan_active;
      logic [14:0] bearing_q6;
      logic [15:0] range_q2;
   } entry_type;

endpackage

// ===== src/lfod_front.sv =====
module lfod_front #(
   parameter int HEADER_LEN = lfod_pkg::HEADER_LEN_DEF
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                accept,
   input  lfod_pkg::req_type   req_data,
   input  lfod_pkg::cfg_type   cfg,
   output lfod_pkg::entry_type entry
);

   localparam int HC_W = $clog2(HEADER_LEN);

   logic [HC_W-1:0]            hc_ff, hc_in;
   logic [1:0]                 lead_ff, lead_in;
   logic                       scan_ff, scan_in;
   logic [lfod_pkg::SC_W-1:0]  sc_ff, sc_in;
   logic [7:0]                 sb_ff [lfod_pkg::SAMPLE_LEN-1];
   logic [7:0]                 sb_in [lfod_pkg::SAMPLE_LEN-1];
   logic [HC_W:0]              hc_step;
   logic [14:0]                ang_dec;
   logic [15:0]                dist_dec;
   logic                       flags_ok;
   logic                       in_window;

   assign hc_step  = {1'b0, hc_ff} + (HC_W+1)'(1);
   assign ang_dec  = {1'b0, sb_ff[2][6:0], sb_ff[1][7:1]};
   assign dist_dec = {req_data.rx_byte, sb_ff[3]};
   assign flags_ok = sb_ff[0][0] != sb_ff[0][1];
   assign in_window = ((ang_dec >= cfg.sector_start_q6) || (ang_dec <= cfg.sector_end_q6))
                      && (dist_dec >= cfg.min_valid_q2) && (dist_dec <= cfg.max_valid_q2);

   always_comb begin
      hc_in   = hc_ff;
      lead_in = lead_ff;
      scan_in = scan_ff;
      sc_in   = sc_ff;
      sb_in   = sb_ff;
      entry.kind       = lfod_pkg::KIND_NONE;
      entry.bearing_q6 = '0;
      entry.range_q2   = '0;
      if (req_data.opcode == lfod_pkg::OP_TICK) begin
         entry.kind = lfod_pkg::KIND_TICK;
      end else if (!scan_ff) begin
         if (hc_ff == '0) begin
            lead_in = (req_data.rx_byte == lfod_pkg::LEAD_FIRST) ?
                      lfod_pkg::LEAD_FIRST_OK : lfod_pkg::LEAD_NONE;
         end else if (hc_ff == HC_W'(1)) begin
            lead_in = lead_ff | ((req_data.rx_byte == lfod_pkg::LEAD_SECOND) ?
                      lfod_pkg::LEAD_SECOND_OK : lfod_pkg::LEAD_NONE);
         end
         if (hc_step >= (HC_W+1)'(HEADER_LEN)) begin
            hc_in = '0;
            if (lead_in == lfod_pkg::LEAD_BOTH) begin
               scan_in = 1'b1;
            end
         end else begin
            hc_in = hc_step[HC_W-1:0];
         end
      end else if (sc_ff < lfod_pkg::SC_W'(lfod_pkg::SAMPLE_LEN - 1)) begin
         sb_in[sc_ff[lfod_pkg::SB_W-1:0]] = req_data.rx_byte;
         sc_in = sc_ff + lfod_pkg::SC_W'(1);
      end else begin
         sc_in = '0;
         if (flags_ok) begin
            entry.bearing_q6 = ang_dec;
            entry.range_q2   = dist_dec;
            entry.kind = in_window ? lfod_pkg::KIND_INSERT : lfod_pkg::KIND_REPORT;
         end
      end
      entry.scan_active = scan_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hc_ff   <= '0;
         lead_ff <= lfod_pkg::LEAD_NONE;
         scan_ff <= 1'b0;
         sc_ff   <= '0;
      end else if (accept) begin
         hc_ff   <= hc_in;
         lead_ff <= lead_in;
         scan_ff <= scan_in;
         sc_ff   <= sc_in;
      end
   end

   // Sample bytes are always written before they are read.
   always_ff @(posedge clock) begin
      if (accept) begin
         sb_ff <= sb_in;
      end
   end

endmodule

// ===== src/lfod_queue.sv =====
module lfod_queue (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  lfod_pkg::entry_type push_entry,
   input  logic                pop,
   output logic                full,
   output logic                head_valid,
   output lfod_pkg::entry_type head_entry
);

   localparam int PTR_W = $clog2(lfod_pkg::QUEUE_DEPTH);
   localparam int CNT_W = $clog2(lfod_pkg::QUEUE_DEPTH + 1);

   lfod_pkg::entry_type mem_ff [lfod_pkg::QUEUE_DEPTH];
   logic [PTR_W-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]    count_ff, count_in;

   assign full       = count_ff == CNT_W'(lfod_pkg::QUEUE_DEPTH);
   assign head_valid = count_ff != '0;
   assign head_entry = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + PTR_W'(1) : wr_ptr_ff;
      rd_ptr_in = pop  ? rd_ptr_ff + PTR_W'(1) : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule

// ===== src/lfod_back.sv =====
module lfod_back #(
   parameter int MEDIAN_TAPS = lfod_pkg::MEDIAN_TAPS_DEF
) (
   input  logic                clock,
   input  logic                reset,
   input  lfod_pkg::cfg_type   cfg,
   input  logic                head_valid,
   input  lfod_pkg::entry_type head_entry,
   output logic                pop,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output lfod_pkg::rsp_type   rsp_data
);

   localparam int RP_W = $clog2(MEDIAN_TAPS);
   localparam int RK_W = $clog2(MEDIAN_TAPS);

   logic [15:0]       ring_ff [MEDIAN_TAPS];
   logic [15:0]       ring_in [MEDIAN_TAPS];
   logic [15:0]       ring_wr [MEDIAN_TAPS];
   logic [RK_W-1:0]   rank [MEDIAN_TAPS];
   logic [RP_W-1:0]   ring_pos_ff, ring_pos_in;
   logic [15:0]       median_ff, median_in, med_sel;
   logic [15:0]       front_ff, front_in;
   logic [7:0]        near_ff, near_in, near_bump;
   logic [7:0]        far_ff, far_in, far_bump;
   logic              obstacle_ff, obstacle_in;
   logic              rsp_valid_ff, rsp_valid_in;
   lfod_pkg::rsp_type rsp_data_ff, rsp_data_in;

   assign pop       = head_valid && (!rsp_valid_ff || !rsp_stall);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   always_comb begin
      ring_wr = ring_ff;
      ring_wr[ring_pos_ff] = head_entry.range_q2;
   end

   // Median by stable rank: ties break on position, so ranks form a permutation.
   always_comb begin
      med_sel = '0;
      for (int i = 0; i < MEDIAN_TAPS; i++) begin
         rank[i] = '0;
         for (int j = 0; j < MEDIAN_TAPS; j++) begin
            if (j != i) begin
               if ((ring_wr[j] < ring_wr[i]) || ((ring_wr[j] == ring_wr[i]) && (j < i))) begin
                  rank[i] = rank[i] + RK_W'(1);
               end
            end
         end
         if (rank[i] == RK_W'(MEDIAN_TAPS / 2)) begin
            med_sel = med_sel | ring_wr[i];
         end
      end
   end

   assign near_bump = (near_ff == lfod_pkg::COUNT_MAX) ? near_ff : near_ff + 8'd1;
   assign far_bump  = (far_ff == lfod_pkg::COUNT_MAX) ? far_ff : far_ff + 8'd1;

   always_comb begin
      ring_in     = ring_ff;
      ring_pos_in = ring_pos_ff;
      median_in   = median_ff;
      front_in    = front_ff;
      near_in     = near_ff;
      far_in      = far_ff;
      obstacle_in = obstacle_ff;
      if (pop) begin
         case (head_entry.kind)
            lfod_pkg::KIND_INSERT: begin
               ring_in     = ring_wr;
               ring_pos_in = (ring_pos_ff == RP_W'(MEDIAN_TAPS - 1)) ?
                             '0 : ring_pos_ff + RP_W'(1);
               median_in   = med_sel;
            end
            lfod_pkg::KIND_TICK: begin
               front_in = median_ff;
               if (median_ff < cfg.near_threshold_q2) begin
                  near_in = near_bump;
                  far_in  = '0;
                  if (near_bump >= cfg.confirm_needed) begin
                     obstacle_in = 1'b1;
                  end
               end else begin
                  near_in = '0;
                  if (obstacle_ff) begin
                     far_in = far_bump;
                     if (far_bump >= cfg.clear_needed) begin
                        obstacle_in = 1'b0;
                        far_in      = '0;
                     end
                  end
               end
            end
            lfod_pkg::KIND_NONE, lfod_pkg::KIND_REPORT: begin
            end
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (pop) begin
         rsp_valid_in               = 1'b1;
         rsp_data_in.scan_active    = head_entry.scan_active;
         rsp_data_in.sample_done    = (head_entry.kind == lfod_pkg::KIND_INSERT) ||
                                      (head_entry.kind == lfod_pkg::KIND_REPORT);
         rsp_data_in.bearing_q6     = head_entry.bearing_q6;
         rsp_data_in.range_q2       = head_entry.range_q2;
         rsp_data_in.median_q2      = median_in;
         rsp_data_in.front_range_q2 = front_in;
         rsp_data_in.obstacle       = obstacle_in;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < MEDIAN_TAPS; k++) begin
            ring_ff[k] <= lfod_pkg::RESET_DIST_Q2;
         end
         ring_pos_ff  <= '0;
         median_ff    <= lfod_pkg::RESET_DIST_Q2;
         front_ff     <= lfod_pkg::RESET_DIST_Q2;
         near_ff      <= '0;
         far_ff       <= '0;
         obstacle_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         ring_ff      <= ring_in;
         ring_pos_ff  <= ring_pos_in;
         median_ff    <= median_in;
         front_ff     <= front_in;
         near_ff      <= near_in;
         far_ff       <= far_in;
         obstacle_ff  <= obstacle_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

endmodule

// ===== src/lidar_front_obstacle_detector.sv =====
// Front obstacle detector for a lidar byte stream. Each request carries
// either a received lidar byte or a periodic update tick, and each gives
// exactly one response. Bytes first fill HEADER_LEN-byte response headers;
// once a header opens A5 5A the block stays in scan mode and groups bytes
// into five-byte samples. A sample whose start flags differ is decoded to
// an angle (degrees * 64) and a distance (mm * 4); when it lies in the
// front sector and the valid distance range it enters a MEDIAN_TAPS-entry
// ring whose median is the filtered distance. A tick latches that median
// and runs saturating near/far counters that raise and clear a debounced
// obstacle flag. Throughput is one request per clock while the queue has
// a free slot. With the response side free, an accepted request is
// written into the queue, popped from it into the response register and
// offered from there as a response; the front decoder feeds a four-entry
// queue, so up to four further requests are taken while a response is
// stalled, and req_stall rises only when that queue is full.
// The critical path is the back end's rank network: one write into the
// ring, MEDIAN_TAPS * (MEDIAN_TAPS - 1) pairs of 16-bit compares, a small
// popcount per tap and the median select, all combinational.
// Configuration registers are written through the csr_ port, which is
// always ready; write them only while no request is in flight.
module lidar_front_obstacle_detector #(
   parameter int HEADER_LEN  = lfod_pkg::HEADER_LEN_DEF,
   parameter int MEDIAN_TAPS = lfod_pkg::MEDIAN_TAPS_DEF
) (
   input  logic              clock,
   input  logic              reset,
   // request channel
   input  logic              req_valid,
   output logic              req_stall,
   input  lfod_pkg::req_type req_data,
   // response channel
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output lfod_pkg::rsp_type rsp_data,
   // configuration writes
   input  logic              csr_valid,
   output logic              csr_ready,
   input  logic [2:0]        csr_index,
   input  logic [15:0]       csr_wdata
);

   lfod_pkg::cfg_type   cfg_ff, cfg_in;
   lfod_pkg::entry_type front_entry;
   lfod_pkg::entry_type head_entry;
   logic                req_accept;
   logic                queue_full;
   logic                head_valid;
   logic                head_pop;

   // Configuration file: always ready, values truncated to register width.
   assign csr_ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid && csr_ready) begin
         case (csr_index)
            lfod_pkg::CSR_NEAR_THRESHOLD: cfg_in.near_threshold_q2 = csr_wdata;
            lfod_pkg::CSR_CONFIRM_NEEDED: cfg_in.confirm_needed    = csr_wdata[7:0];
            lfod_pkg::CSR_CLEAR_NEEDED:   cfg_in.clear_needed      = csr_wdata[7:0];
            lfod_pkg::CSR_MIN_VALID:      cfg_in.min_valid_q2      = csr_wdata;
            lfod_pkg::CSR_MAX_VALID:      cfg_in.max_valid_q2      = csr_wdata;
            lfod_pkg::CSR_SECTOR_START:   cfg_in.sector_start_q6   = csr_wdata[14:0];
            lfod_pkg::CSR_SECTOR_END:     cfg_in.sector_end_q6     = csr_wdata[14:0];
            default: begin
               // drop writes to unmapped indexes
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.near_threshold_q2 <= lfod_pkg::NEAR_THRESHOLD_RST;
         cfg_ff.confirm_needed    <= lfod_pkg::CONFIRM_NEEDED_RST;
         cfg_ff.clear_needed      <= lfod_pkg::CLEAR_NEEDED_RST;
         cfg_ff.min_valid_q2      <= lfod_pkg::MIN_VALID_RST;
         cfg_ff.max_valid_q2      <= lfod_pkg::MAX_VALID_RST;
         cfg_ff.sector_start_q6   <= lfod_pkg::SECTOR_START_RST;
         cfg_ff.sector_end_q6     <= lfod_pkg::SECTOR_END_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // Hold off the sender only while the queue has no free slot.
   assign req_stall  = queue_full;
   assign req_accept = req_valid && !req_stall;

   // Front: header parsing, sample assembly and sector/range classification.
   lfod_front #(
      .HEADER_LEN (HEADER_LEN)
   ) u_front (
      .clock    (clock),
      .reset    (reset),
      .accept   (req_accept),
      .req_data (req_data),
      .cfg      (cfg_ff),
      .entry    (front_entry)
   );

   // Decouple the decoder from the filter so each side stalls on its own.
   lfod_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (req_accept),
      .push_entry (front_entry),
      .pop        (head_pop),
      .full       (queue_full),
      .head_valid (head_valid),
      .head_entry (head_entry)
   );

   // Back: median ring, tick debounce and the response register.
   lfod_back #(
      .MEDIAN_TAPS (MEDIAN_TAPS)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .head_valid (head_valid),
      .head_entry (head_entry),
      .pop        (head_pop),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .rsp_data   (rsp_data)
   );

endmodule

// ===== src/lfod_checker.sv =====
`include "lidar_front_obstacle_detector_macros.svh"

module lfod_checker (
   input logic              clock,
   input logic              reset,
   input logic              req_valid,
   input logic              req_stall,
   input logic              rsp_valid,
   input logic              rsp_stall,
   input lfod_pkg::rsp_type rsp_data
);

   logic [3:0] pending_ff, pending_in;
   logic       seen_scan_ff, seen_scan_in;
   logic       req_take;
   logic       rsp_take;
   logic       fields_zero;

   assign req_take    = req_valid && !req_stall;
   assign rsp_take    = rsp_valid && !rsp_stall;
   assign fields_zero = (rsp_data.bearing_q6 == 15'd0) && (rsp_data.range_q2 == 16'd0);

   always_comb begin
      pending_in = pending_ff;
      if (req_take && !rsp_take) begin
         pending_in = pending_ff + 4'd1;
      end else if (rsp_take && !req_take) begin
         pending_in = pending_ff - 4'd1;
      end
      seen_scan_in = seen_scan_ff || (rsp_take && rsp_data.scan_active);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pending_ff   <= '0;
         seen_scan_ff <= 1'b0;
      end else begin
         pending_ff   <= pending_in;
         seen_scan_ff <= seen_scan_in;
      end
   end

   `LFOD_ASSERT_NOW(a_no_invented_rsp, clock, reset, rsp_valid, pending_ff != 4'd0)
   `LFOD_ASSERT_NOW(a_scan_sticky, clock, reset, rsp_valid && seen_scan_ff, rsp_data.scan_active)
   `LFOD_ASSERT_NOW(a_idle_fields_zero, clock, reset, rsp_valid && !rsp_data.sample_done, fields_zero)
   `LFOD_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_data))

endmodule

bind lidar_front_obstacle_detector lfod_checker u_lfod_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_stall (req_stall),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_data  (rsp_data)
);

// ===== tb/tb_top.sv =====
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   // Geometry of the instance; the predictor follows the same values.
   localparam int HDR_BYTES = lfod_pkg::HEADER_LEN_DEF;
   localparam int TAPS      = lfod_pkg::MEDIAN_TAPS_DEF;

   // Largest angle that five-byte framing can encode (7 + 7 bits).
   localparam int ANGLE_TOP = 16383;

   // Cycles to let pass once nothing is awaited.
   localparam int SETTLE    = 4;
   localparam int LIMIT     = 500000;
   localparam int PRINT_CAP = 100;

   localparam int N_REGS    = 7;
   localparam int N_PHASES  = 8;
   localparam int N_FIXED   = 5;
   // Phases that end in a long run of update ticks (near count saturation, then flag drain).
   localparam int SATURATE_PHASE = 1;
   localparam int DRAIN_PHASE    = 2;
   localparam int TICK_RUN       = 300;
   localparam int PHASE_ITEMS    = 135;

   // An index past the register list; a write there must change nothing.
   localparam logic [2:0] CSR_UNUSED = 3'd7;

   typedef enum int {
      STALL_NONE,
      STALL_RANDOM,
      STALL_PERIODIC,
      STALL_LONG
   } stall_mode_type;

   typedef struct {
      lfod_pkg::req_type stim;
      lfod_pkg::rsp_type want;
   } directed_row_type;

   // ---------------------------------------------------------------------
   // Clock, reset and the block's inputs, all known from time zero.
   // ---------------------------------------------------------------------
   logic              clock     = 1'b0;
   logic              reset     = 1'b1;
   logic              req_valid = 1'b0;
   logic              req_stall;
   lfod_pkg::req_type req_data  = '0;
   logic              rsp_valid;
   logic              rsp_stall = 1'b0;
   lfod_pkg::rsp_type rsp_data;
   logic              csr_valid = 1'b0;
   logic              csr_ready;
   logic [2:0]        csr_index = '0;
   logic [15:0]       csr_wdata = '0;

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   lidar_front_obstacle_detector #(
      .HEADER_LEN  (HDR_BYTES),
      .MEDIAN_TAPS (TAPS)
   ) u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   // ---------------------------------------------------------------------
   // Predictor state: a shadow of the detector, kept in step with every
   // accepted request and every register write.
   // ---------------------------------------------------------------------
   lfod_pkg::cfg_type cfg = '{lfod_pkg::NEAR_THRESHOLD_RST, lfod_pkg::CONFIRM_NEEDED_RST,
                              lfod_pkg::CLEAR_NEEDED_RST, lfod_pkg::MIN_VALID_RST,
                              lfod_pkg::MAX_VALID_RST, lfod_pkg::SECTOR_START_RST,
                              lfod_pkg::SECTOR_END_RST};
   int          hdr_count     = 0;
   logic [1:0]  hdr_lead      = lfod_pkg::LEAD_NONE;
   logic        scanning      = 1'b0;
   logic [7:0]  smp_bytes [lfod_pkg::SAMPLE_LEN-1] = '{default: 8'h00};
   int          smp_count     = 0;
   logic [15:0] ring [TAPS]   = '{default: lfod_pkg::RESET_DIST_Q2};
   int          ring_wr       = 0;
   logic [15:0] filt_median   = lfod_pkg::RESET_DIST_Q2;
   logic [15:0] front_held    = lfod_pkg::RESET_DIST_Q2;
   logic [7:0]  near_run      = '0;
   logic [7:0]  far_run       = '0;
   logic        obstacle_held = 1'b0;

   lfod_pkg::rsp_type due_readings [$];
   int          mismatches    = 0;
   int          items_sent    = 0;
   int          burst_left    = 0;
   int unsigned cycle_count   = 0;

   directed_row_type directed_rows [$];

   // Register words per phase. Rows past the fixed ones are filled at random.
   logic [15:0] phase_words [N_PHASES][N_REGS] = '{
      // everything counts as front, full distance range, minimum extremes
      '{16'd2000,  16'd3,     16'd4,     16'd0,   16'd65535, 16'd0,     16'd0},
      // every median is near; confirm at its top so the near count saturates
      '{16'd65535, 16'd255,   16'd255,   16'd0,   16'd65535, 16'd32767, 16'd16383},
      // nothing near, empty valid range, start masked down from all ones
      '{16'd0,     16'd1,     16'd1,     16'd100, 16'd50,    16'hFFFF,  16'd0},
      // zero confirm and clear counts after masking; stray upper bits
      '{16'd1500,  16'hFF00,  16'h0100,  16'd300, 16'd3000,  16'hCE20,  16'd2000},
      // ordinary narrow sector
      '{16'd3000,  16'd2,     16'd6,     16'd200, 16'd8000,  16'd12000, 16'd4000},
      '{default: 16'd0},
      '{default: 16'd0},
      '{default: 16'd0}
   };

   // Median as the entry whose rank window covers the middle position.
   function automatic logic [15:0] ring_median();
      int          i;
      int          j;
      int          lt;
      int          le;
      logic [15:0] m;
      m = ring[0];
      for (i = 0; i < TAPS; i++) begin
         lt = 0;
         le = 0;
         for (j = 0; j < TAPS; j++) begin
            if (ring[j] < ring[i]) lt++;
            if (ring[j] <= ring[i]) le++;
         end
         if (lt <= TAPS / 2 && TAPS / 2 < le) m = ring[i];
      end
      return m;
   endfunction

   // Advance the shadow by one request and return the reading it yields.
   task automatic predict_reading(input lfod_pkg::req_type stim,
                                  output lfod_pkg::rsp_type reading);
      logic        done;
      logic [14:0] ang;
      logic [15:0] d_q2;
      logic [7:0]  flags;
      done = 1'b0;
      ang  = '0;
      d_q2 = '0;
      if (stim.opcode == lfod_pkg::OP_TICK) begin
         // Latch the median, then run the debounce counters.
         front_held = filt_median;
         if (filt_median < cfg.near_threshold_q2) begin
            if (near_run < lfod_pkg::COUNT_MAX) near_run++;
            far_run = '0;
            if (near_run >= cfg.confirm_needed) obstacle_held = 1'b1;
         end else begin
            near_run = '0;
            if (obstacle_held) begin
               if (far_run < lfod_pkg::COUNT_MAX) far_run++;
               if (far_run >= cfg.clear_needed) begin
                  obstacle_held = 1'b0;
                  far_run       = '0;
               end
            end
         end
      end else if (!scanning) begin
         // Header bytes: only the first two matter, scan mode is sticky.
         if (hdr_count == 0) begin
            hdr_lead = lfod_pkg::LEAD_NONE;
            if (stim.rx_byte == lfod_pkg::LEAD_FIRST) hdr_lead |= lfod_pkg::LEAD_FIRST_OK;
         end else if (hdr_count == 1 && stim.rx_byte == lfod_pkg::LEAD_SECOND) begin
            hdr_lead |= lfod_pkg::LEAD_SECOND_OK;
         end
         hdr_count++;
         if (hdr_count >= HDR_BYTES) begin
            hdr_count = 0;
            if (hdr_lead == lfod_pkg::LEAD_BOTH) scanning = 1'b1;
         end
      end else if (smp_count < lfod_pkg::SAMPLE_LEN - 1) begin
         smp_bytes[smp_count] = stim.rx_byte;
         smp_count++;
      end else begin
         smp_count = 0;
         flags     = smp_bytes[0];
         if (flags[0] != flags[1]) begin
            done = 1'b1;
            ang  = {1'b0, smp_bytes[2][6:0], smp_bytes[1][7:1]};
            d_q2 = {stim.rx_byte, smp_bytes[3]};
            if ((ang >= cfg.sector_start_q6 || ang <= cfg.sector_end_q6) &&
                d_q2 >= cfg.min_valid_q2 && d_q2 <= cfg.max_valid_q2) begin
               ring[ring_wr] = d_q2;
               ring_wr       = (ring_wr + 1) % TAPS;
               filt_median   = ring_median();
            end
         end
      end
      reading.scan_active    = scanning;
      reading.sample_done    = done;
      reading.bearing_q6     = ang;
      reading.range_q2       = d_q2;
      reading.median_q2      = filt_median;
      reading.front_range_q2 = front_held;
      reading.obstacle       = obstacle_held;
   endtask

   // ---------------------------------------------------------------------
   // Checking
   // ---------------------------------------------------------------------
   task automatic log_mismatch(input string what);
      if (mismatches < PRINT_CAP) $display("[%0t] mismatch: %s", $realtime, what);
      mismatches++;
   endtask

   task automatic compare_field(input string name, input logic [15:0] got,
                                input logic [15:0] want);
      if (got !== want)
         log_mismatch($sformatf("%s got %0d, expected %0d", name, got, want));
   endtask

   // Compare each accepted response with the oldest awaited reading.
   always @(posedge clock) begin : check_responses
      lfod_pkg::rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (due_readings.size() == 0) begin
            log_mismatch("response with no request outstanding");
         end else begin
            want = due_readings.pop_front();
            compare_field("scan_active", 16'(rsp_data.scan_active), 16'(want.scan_active));
            compare_field("sample_done", 16'(rsp_data.sample_done), 16'(want.sample_done));
            compare_field("bearing_q6", 16'(rsp_data.bearing_q6), 16'(want.bearing_q6));
            compare_field("range_q2", rsp_data.range_q2, want.range_q2);
            compare_field("median_q2", rsp_data.median_q2, want.median_q2);
            compare_field("front_range_q2", rsp_data.front_range_q2,
                          want.front_range_q2);
            compare_field("obstacle", 16'(rsp_data.obstacle), 16'(want.obstacle));
         end
      end
   end

   // Abandon a hung run.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= LIMIT) begin
         $display("end of test: mismatches");
         $finish;
      end
   end

   // ---------------------------------------------------------------------
   // Response side: stall in a mode drawn at random anew whenever the current
   // one runs out: never, random, periodic or long holds.
   // ---------------------------------------------------------------------
   stall_mode_type stall_mode = STALL_NONE;
   int             mode_left  = 0;
   int             hold_left  = 0;
   int             stall_tick = 0;

   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (mode_left == 0) begin
            stall_mode = stall_mode_type'($urandom_range(0, 3));
            mode_left  = $urandom_range(50, 300);
         end
         mode_left--;
         stall_tick++;
         case (stall_mode)
            STALL_NONE: begin
               rsp_stall <= 1'b0;
            end
            STALL_RANDOM: begin
               rsp_stall <= ($urandom_range(0, 2) == 0);
            end
            STALL_PERIODIC: begin
               rsp_stall <= (stall_tick % 7 < 3);
            end
            default: begin
               if (hold_left > 0) begin
                  hold_left--;
                  rsp_stall <= 1'b1;
               end else if ($urandom_range(0, 15) == 0) begin
                  hold_left = $urandom_range(4, 20);
                  rsp_stall <= 1'b1;
               end else begin
                  rsp_stall <= 1'b0;
               end
            end
         endcase
      end
   end

   // ---------------------------------------------------------------------
   // Request side
   // ---------------------------------------------------------------------

   // Drop valid and hold until every awaited reading has come back.
   task automatic wait_all_returned();
      req_valid <= 1'b0;
      while (due_readings.size() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   // Offer one request, hold it through stalls, then record what it should
   // give: the typed-in reading for directed rows, else the predictor's.
   // Gaps fall between bursts of random length.
   task automatic drive_request(input lfod_pkg::req_type stim, input bit typed,
                                input lfod_pkg::rsp_type typed_want);
      lfod_pkg::rsp_type reading;
      req_valid <= 1'b1;
      req_data  <= stim;
      do @(posedge clock); while (req_stall);
      predict_reading(stim, reading);
      due_readings.push_back(typed ? typed_want : reading);
      items_sent++;
      burst_left--;
      if (burst_left <= 0) begin
         burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 300)
                                                   : $urandom_range(1, 24);
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 8)) @(posedge clock);
      end else if ($urandom_range(0, 299) == 0) begin
         wait_all_returned();
      end
   endtask

   task automatic send_byte(input logic [7:0] b);
      drive_request('{lfod_pkg::OP_BYTE, b}, 1'b0, '0);
   endtask

   task automatic send_tick();
      drive_request('{lfod_pkg::OP_TICK, 8'($urandom)}, 1'b0, '0);
   endtask

   // Write one register and mirror it, masked to the register's width.
   task automatic write_register(input logic [2:0] idx, input logic [15:0] wdata);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= wdata;
      do @(posedge clock); while (!csr_ready);
      case (idx)
         lfod_pkg::CSR_NEAR_THRESHOLD: cfg.near_threshold_q2 = wdata;
         lfod_pkg::CSR_CONFIRM_NEEDED: cfg.confirm_needed    = wdata[7:0];
         lfod_pkg::CSR_CLEAR_NEEDED:   cfg.clear_needed      = wdata[7:0];
         lfod_pkg::CSR_MIN_VALID:      cfg.min_valid_q2      = wdata;
         lfod_pkg::CSR_MAX_VALID:      cfg.max_valid_q2      = wdata;
         lfod_pkg::CSR_SECTOR_START:   cfg.sector_start_q6   = wdata[14:0];
         lfod_pkg::CSR_SECTOR_END:     cfg.sector_end_q6     = wdata[14:0];
         default: ;
      endcase
   endtask

   // Angle in or out of the current front sector.
   function automatic logic [13:0] pick_angle(input bit want_front);
      int a;
      int tries;
      if (want_front) begin
         if (cfg.sector_start_q6 <= ANGLE_TOP && $urandom_range(0, 1) == 1)
            return 14'($urandom_range(cfg.sector_start_q6, ANGLE_TOP));
         return 14'($urandom_range(0, (cfg.sector_end_q6 > ANGLE_TOP) ? ANGLE_TOP
                                                                      : cfg.sector_end_q6));
      end
      a = $urandom_range(0, ANGLE_TOP);
      for (tries = 0; tries < 8; tries++) begin
         if (!(a >= cfg.sector_start_q6 || a <= cfg.sector_end_q6)) break;
         a = $urandom_range(0, ANGLE_TOP);
      end
      return 14'(a);
   endfunction

   // Distance in the valid range, on the near or far side of the threshold,
   // with the range edges themselves hit now and then.
   function automatic logic [15:0] pick_distance(input bit want_near);
      int lo;
      int hi;
      lo = cfg.min_valid_q2;
      hi = cfg.max_valid_q2;
      if (want_near) begin
         if (cfg.near_threshold_q2 > 0 && cfg.near_threshold_q2 - 1 < hi)
            hi = cfg.near_threshold_q2 - 1;
      end else if (cfg.near_threshold_q2 > lo) begin
         lo = cfg.near_threshold_q2;
      end
      if (lo > hi) return 16'($urandom);
      case ($urandom_range(0, 9))
         0:       return 16'(lo);
         1:       return 16'(hi);
         default: return 16'($urandom_range(lo, hi));
      endcase
   endfunction

   // Mostly well-formed samples steered towards a near or far scene, with
   // ticks between and inside samples, and stray bytes that break framing.
   task automatic stream_scene(input int n_items);
      int          target;
      int          i;
      bit          want_near;
      logic [7:0]  flags;
      logic [13:0] a;
      logic [15:0] d_q2;
      logic [7:0]  frame [lfod_pkg::SAMPLE_LEN];
      target    = items_sent + n_items;
      want_near = $urandom_range(0, 1);
      while (items_sent < target) begin
         // Realign to a sample boundary after stray bytes.
         while (smp_count != 0) send_byte(8'($urandom));
         if ($urandom_range(0, 19) == 0) want_near = !want_near;
         case ($urandom_range(0, 19))
            0, 1, 2, 3, 4: begin
               send_tick();
            end
            5: begin
               repeat ($urandom_range(1, lfod_pkg::SAMPLE_LEN - 1)) send_byte(8'($urandom));
            end
            default: begin
               flags    = 8'($urandom);
               flags[1] = ($urandom_range(0, 9) < 8) ? !flags[0] : flags[0];
               a        = pick_angle($urandom_range(0, 9) < 8);
               d_q2     = ($urandom_range(0, 9) < 8) ? pick_distance(want_near)
                                                     : 16'($urandom);
               frame[0] = flags;
               frame[1] = {a[6:0], 1'($urandom)};
               frame[2] = {1'($urandom), a[13:7]};
               frame[3] = d_q2[7:0];
               frame[4] = d_q2[15:8];
               for (i = 0; i < lfod_pkg::SAMPLE_LEN; i++) begin
                  if ($urandom_range(0, 9) == 0) send_tick();
                  send_byte(frame[i]);
               end
            end
         endcase
      end
   endtask

   task automatic add_row(input logic op, input logic [7:0] b, input logic scan,
                          input logic done, input logic [14:0] ang,
                          input logic [15:0] d_q2);
      directed_row_type row;
      row.stim = '{op, b};
      row.want = '{scan, done, ang, d_q2, lfod_pkg::RESET_DIST_Q2,
                   lfod_pkg::RESET_DIST_Q2, 1'b0};
      directed_rows.push_back(row);
   endtask

   // ---------------------------------------------------------------------
   // Main sequence
   // ---------------------------------------------------------------------
   initial begin : run_sequence
      int p;
      int r;
      int i;

      // Directed rows, reset settings throughout. The median stays at its
      // reset value, so only the framing fields move.
      // a tick before anything else: far, flag stays low, byte ignored
      add_row(lfod_pkg::OP_TICK, 8'hFF, 1'b0, 1'b0, 15'd0, 16'd0);
      // header whose second byte is wrong: no scan mode
      add_row(lfod_pkg::OP_BYTE, 8'hA5, 1'b0, 1'b0, 15'd0, 16'd0);
      add_row(lfod_pkg::OP_BYTE, 8'hA5, 1'b0, 1'b0, 15'd0, 16'd0);
      add_row(lfod_pkg::OP_BYTE, 8'h00, 1'b0, 1'b0, 15'd0, 16'd0);
      add_row(lfod_pkg::OP_BYTE, 8'hFF, 1'b0, 1'b0, 15'd0, 16'd0);
      add_row(lfod_pkg::OP_BYTE, 8'h12, 1'b0, 1'b0, 15'd0, 16'd0);
      add_row(lfod_pkg::OP_BYTE, 8'h34, 1'b0, 1'b0, 15'd0, 16'd0);
      add_row(lfod_pkg::OP_BYTE, 8'h56, 1'b0, 1'b0, 15'd0, 16'd0);
      // proper header: scan mode on its last byte
      add_row(lfod_pkg::OP_BYTE, 8'hA5, 1'b0, 1'b0, 15'd0, 16'd0);
      add_row(lfod_pkg::OP_BYTE, 8'h5A, 1'b0, 1'b0, 15'd0, 16'd0);
      add_row(lfod_pkg::OP_BYTE, 8'h05, 1'b0, 1'b0, 15'd0, 16'd0);
      add_row(lfod_pkg::OP_BYTE, 8'h00, 1'b0, 1'b0, 15'd0, 16'd0);
      add_row(lfod_pkg::OP_BYTE, 8'h00, 1'b0, 1'b0, 15'd0, 16'd0);
      add_row(lfod_pkg::OP_BYTE, 8'h40, 1'b0, 1'b0, 15'd0, 16'd0);
      add_row(lfod_pkg::OP_BYTE, 8'h81, 1'b1, 1'b0, 15'd0, 16'd0);
      // sample of all ones after a good flag: top angle and distance,
      // outside the sector and the range, so the ring is untouched
      add_row(lfod_pkg::OP_BYTE, 8'h01, 1'b1, 1'b0, 15'd0, 16'd0);
      add_row(lfod_pkg::OP_BYTE, 8'hFF, 1'b1, 1'b0, 15'd0, 16'd0);
      add_row(lfod_pkg::OP_BYTE, 8'hFF, 1'b1, 1'b0, 15'd0, 16'd0);
      add_row(lfod_pkg::OP_BYTE, 8'hFF, 1'b1, 1'b0, 15'd0, 16'd0);
      add_row(lfod_pkg::OP_BYTE, 8'hFF, 1'b1, 1'b1, 15'd16383, 16'd65535);
      // both start flags clear: the sample is dropped
      add_row(lfod_pkg::OP_BYTE, 8'h00, 1'b1, 1'b0, 15'd0, 16'd0);
      add_row(lfod_pkg::OP_BYTE, 8'h00, 1'b1, 1'b0, 15'd0, 16'd0);
      add_row(lfod_pkg::OP_BYTE, 8'h00, 1'b1, 1'b0, 15'd0, 16'd0);
      add_row(lfod_pkg::OP_BYTE, 8'h00, 1'b1, 1'b0, 15'd0, 16'd0);
      add_row(lfod_pkg::OP_BYTE, 8'h00, 1'b1, 1'b0, 15'd0, 16'd0);

      // Hold reset from time zero, then release it at an edge.
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_rows[i])
         drive_request(directed_rows[i].stim, 1'b1, directed_rows[i].want);

      // Random traffic under reset settings first.
      stream_scene(PHASE_ITEMS);

      for (p = 0; p < N_PHASES; p++) begin
         // Registers change only with nothing in flight.
         wait_all_returned();
         if (p >= N_FIXED) begin
            phase_words[p][lfod_pkg::CSR_NEAR_THRESHOLD] = 16'($urandom_range(0, 6000));
            phase_words[p][lfod_pkg::CSR_CONFIRM_NEEDED] =
               {8'($urandom), 8'($urandom_range(0, 8))};
            phase_words[p][lfod_pkg::CSR_CLEAR_NEEDED]   =
               {8'($urandom), 8'($urandom_range(0, 12))};
            phase_words[p][lfod_pkg::CSR_MIN_VALID]      = 16'($urandom_range(0, 3000));
            phase_words[p][lfod_pkg::CSR_MAX_VALID]      = 16'($urandom_range(1000, 20000));
            phase_words[p][lfod_pkg::CSR_SECTOR_START]   = 16'($urandom);
            phase_words[p][lfod_pkg::CSR_SECTOR_END]     = 16'($urandom);
         end
         for (r = 0; r < N_REGS; r++) write_register(3'(r), phase_words[p][r]);
         if (p == 0 || $urandom_range(0, 1) == 1)
            write_register(CSR_UNUSED, 16'($urandom));
         csr_valid <= 1'b0;

         stream_scene(PHASE_ITEMS);
         // Long tick runs: saturate the near count, then drain the flag.
         if (p == SATURATE_PHASE || p == DRAIN_PHASE)
            for (i = 0; i < TICK_RUN; i++) send_tick();
      end

      wait_all_returned();
      if (mismatches == 0 && due_readings.size() == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

endmodule
